### rtl/ridap_pkg.sv
// Shared constants for the Remote ID advertisement parser.
package ridap_pkg;

	// Defaults for the top-level parameters.
	localparam int ID_BYTES_DEF      = 20;
	localparam int MAX_ADV_BYTES_DEF = 255;

	// Depth of the run queue between the parser and the result sequencer.
	localparam int RUN_QUEUE_DEPTH = 2;

	// Fixed field widths.
	localparam int BYTE_W  = 8;
	localparam int ADDR_W  = 48;
	localparam int OUT_N_W = 5;

	// Structure matching progress.
	localparam logic [1:0] STG_SCAN  = 2'd0;
	localparam logic [1:0] STG_CAND  = 2'd1;
	localparam logic [1:0] STG_MARK  = 2'd2;
	localparam logic [1:0] STG_BASIC = 2'd3;

	// Advertising structure codes and offsets.
	localparam logic [7:0] SVC_DATA_TYPE  = 8'h16;
	localparam logic [7:0] UUID_LO        = 8'hFA;
	localparam logic [7:0] UUID_HI        = 8'hFF;
	localparam logic [7:0] APP_CODE       = 8'h0D;
	localparam logic [3:0] BASIC_ID_MSG   = 4'h0;
	localparam logic [7:0] MIN_SVC_LEN    = 8'd5;
	localparam logic [7:0] OFF_LEN        = 8'd0;
	localparam logic [7:0] OFF_TYPE       = 8'd1;
	localparam logic [7:0] OFF_UUID_LO    = 8'd2;
	localparam logic [7:0] OFF_UUID_HI    = 8'd3;
	localparam logic [7:0] OFF_APP        = 8'd4;
	localparam logic [7:0] OFF_MSG_HDR    = 8'd6;
	localparam int         OFF_ID         = 8;
	localparam int         EXTRA_LEN      = 7;

	// Printable character window, low bound inclusive, high bound exclusive.
	localparam logic [7:0] PRINT_LO = 8'd32;
	localparam logic [7:0] PRINT_HI = 8'd127;

endpackage

### rtl/remote_id_adv_parser_core.sv
// Top level of the Remote ID advertisement parser: walker, run queue and sequencer.
//
// The input channel carries one advertising payload byte per item, with
// byte_last set on the final byte; signal_strength and station_addr are
// sampled only with that final byte. The block walks the length-type
// structures as the bytes pass and looks for the Remote ID service-data
// marker, keeping the printable prefix of a Basic ID message.
// The output channel carries one run per advertisement: a single item when
// no ID characters were kept, otherwise one item per character, in order,
// with last_result set on the final item of the run.
// Throughput: one byte per cycle while in_ready, one item per cycle while out_ready.
// Once the final byte is accepted, its descriptor is written into the run queue,
// and the first item of the run is loaded from there into the output register.
// Each finished advertisement is held as a descriptor in a two-entry queue,
// so the walker keeps taking bytes while the sequencer drains a run; a
// descriptor leaves the queue when its last item is loaded. Input ready drops
// only while that queue is full, which happens when the receiver stalls or
// when short advertisements arrive faster than a long run drains.
// Reset clears all parse state, the queue and the output valid.
module remote_id_adv_parser_core #(
	parameter int ID_BYTES      = ridap_pkg::ID_BYTES_DEF,
	parameter int MAX_ADV_BYTES = ridap_pkg::MAX_ADV_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ridap_pkg::BYTE_W-1:0]        adv_byte,
	input  logic                                byte_last,
	input  logic signed [ridap_pkg::BYTE_W-1:0] signal_strength,
	input  logic [ridap_pkg::ADDR_W-1:0]        station_addr,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                is_drone,
	output logic signed [ridap_pkg::BYTE_W-1:0] hit_strength,
	output logic [ridap_pkg::ADDR_W-1:0]        hit_addr,
	output logic [ridap_pkg::OUT_N_W-1:0]       id_length,
	output logic [ridap_pkg::OUT_N_W-1:0]       char_index,
	output logic [ridap_pkg::BYTE_W-1:0]        id_char,
	output logic                                last_result
);
	import ridap_pkg::*;

	localparam int CNT_W  = $clog2(ID_BYTES + 1);
	// Descriptor layout: drone flag, strength, address, char count, characters.
	localparam int DESC_W = 1 + BYTE_W + ADDR_W + CNT_W + ID_BYTES * BYTE_W;

	logic                             queue_full;
	logic                             run_push;
	logic                             push_drone;
	logic signed [BYTE_W-1:0]         push_strength;
	logic [ADDR_W-1:0]                push_addr;
	logic [CNT_W-1:0]                 push_cnt;
	logic [ID_BYTES-1:0][BYTE_W-1:0]  push_chars;
	logic [DESC_W-1:0]                push_desc;

	logic                             head_valid;
	logic                             head_pop;
	logic [DESC_W-1:0]                head_desc;
	logic                             head_drone;
	logic signed [BYTE_W-1:0]         head_strength;
	logic [ADDR_W-1:0]                head_addr;
	logic [CNT_W-1:0]                 head_cnt;
	logic [ID_BYTES-1:0][BYTE_W-1:0]  head_chars;

	// The walker consumes bytes and produces a descriptor on the final byte.
	ridap_front #(
		.ID_BYTES      (ID_BYTES),
		.MAX_ADV_BYTES (MAX_ADV_BYTES),
		.CNT_W         (CNT_W)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.adv_byte        (adv_byte),
		.byte_last       (byte_last),
		.signal_strength (signal_strength),
		.station_addr    (station_addr),
		.queue_full      (queue_full),
		.run_push        (run_push),
		.run_drone       (push_drone),
		.run_strength    (push_strength),
		.run_addr        (push_addr),
		.run_cnt         (push_cnt),
		.run_chars       (push_chars)
	);

	assign push_desc = {push_drone, push_strength, push_addr, push_cnt, push_chars};

	// Descriptors wait here so the walker and sequencer stall independently.
	ridap_queue #(
		.DATA_W (DESC_W),
		.DEPTH  (RUN_QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (run_push),
		.push_data  (push_desc),
		.full       (queue_full),
		.pop        (head_pop),
		.head_valid (head_valid),
		.head_data  (head_desc)
	);

	assign {head_drone, head_strength, head_addr, head_cnt, head_chars} = head_desc;

	// The sequencer turns the head descriptor into result items.
	ridap_back #(
		.ID_BYTES (ID_BYTES),
		.CNT_W    (CNT_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_pop     (head_pop),
		.run_drone    (head_drone),
		.run_strength (head_strength),
		.run_addr     (head_addr),
		.run_cnt      (head_cnt),
		.run_chars    (head_chars),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.is_drone     (is_drone),
		.hit_strength (hit_strength),
		.hit_addr     (hit_addr),
		.id_length    (id_length),
		.char_index   (char_index),
		.id_char      (id_char),
		.last_result  (last_result)
	);

endmodule

### rtl/ridap_queue.sv
// Small first-in first-out queue of finished run descriptors.
module ridap_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output logic [DATA_W-1:0] head_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### rtl/ridap_front.sv
// Byte-level structure walker: matches the Remote ID marker and captures the ID.
module ridap_front #(
	parameter int ID_BYTES      = ridap_pkg::ID_BYTES_DEF,
	parameter int MAX_ADV_BYTES = ridap_pkg::MAX_ADV_BYTES_DEF,
	parameter int CNT_W         = $clog2(ID_BYTES + 1)
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [ridap_pkg::BYTE_W-1:0]            adv_byte,
	input  logic                                    byte_last,
	input  logic signed [ridap_pkg::BYTE_W-1:0]     signal_strength,
	input  logic [ridap_pkg::ADDR_W-1:0]            station_addr,
	input  logic                                    queue_full,
	output logic                                    run_push,
	output logic                                    run_drone,
	output logic signed [ridap_pkg::BYTE_W-1:0]     run_strength,
	output logic [ridap_pkg::ADDR_W-1:0]            run_addr,
	output logic [CNT_W-1:0]                        run_cnt,
	output logic [ID_BYTES-1:0][ridap_pkg::BYTE_W-1:0] run_chars
);
	import ridap_pkg::*;

	localparam int IDX_W = (ID_BYTES > 1) ? $clog2(ID_BYTES) : 1;
	localparam int MIN_FIELD_LEN = ID_BYTES + EXTRA_LEN;

	logic [7:0]       pos_q, pos_n;
	logic [8:0]       fstart_q, fstart_n;
	logic [7:0]       flen_q, flen_n;
	logic [1:0]       stage_q, stage_n;
	logic             done_q, done_n;
	logic             found_q, found_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic             stopped_q, stopped_n;
	logic [BYTE_W-1:0] store_q [ID_BYTES];

	logic             accept;
	logic [7:0]       off;
	logic             st_we;
	logic [IDX_W-1:0] st_idx;
	logic             printable;
	logic             drone;
	logic [9:0]       field_end;

	assign in_ready  = !queue_full;
	assign accept    = in_valid && in_ready;
	assign off       = 8'({1'b0, pos_q} - fstart_q);
	assign printable = (adv_byte >= PRINT_LO) && (adv_byte < PRINT_HI);
	assign st_idx    = IDX_W'(cnt_q);

	always_comb begin
		pos_n     = pos_q;
		fstart_n  = fstart_q;
		flen_n    = flen_q;
		stage_n   = stage_q;
		done_n    = done_q;
		found_n   = found_q;
		cnt_n     = cnt_q;
		stopped_n = stopped_q;
		st_we     = 1'b0;
		if (accept && pos_q < 8'(MAX_ADV_BYTES)) begin
			pos_n = pos_q + 8'd1;
			if (!done_q && {1'b0, pos_q} >= fstart_q) begin
				if (off == OFF_LEN) begin
					flen_n = adv_byte;
					if (adv_byte == 8'd0) begin
						done_n = 1'b1;
					end
				end else begin
					if (off == OFF_TYPE) begin
						stage_n = (adv_byte == SVC_DATA_TYPE && flen_q >= MIN_SVC_LEN) ?
							STG_CAND : STG_SCAN;
					end else if (off == OFF_UUID_LO) begin
						if (stage_q == STG_CAND && adv_byte != UUID_LO) begin
							stage_n = STG_SCAN;
						end
					end else if (off == OFF_UUID_HI) begin
						if (stage_q == STG_CAND && adv_byte != UUID_HI) begin
							stage_n = STG_SCAN;
						end
					end else if (off == OFF_APP) begin
						if (stage_q == STG_CAND) begin
							if (adv_byte == APP_CODE) begin
								stage_n = STG_MARK;
								found_n = 1'b1;
							end else begin
								stage_n = STG_SCAN;
							end
						end
					end else if (off == OFF_MSG_HDR) begin
						if (stage_q == STG_MARK && adv_byte[7:4] == BASIC_ID_MSG &&
							flen_q >= 8'(MIN_FIELD_LEN)) begin
							stage_n = STG_BASIC;
						end
					end else if (off >= 8'(OFF_ID) && off < 8'(OFF_ID + ID_BYTES)) begin
						if (stage_q == STG_BASIC && !stopped_q) begin
							if (printable && cnt_q < CNT_W'(ID_BYTES)) begin
								st_we = 1'b1;
								cnt_n = cnt_q + 1'b1;
							end else begin
								stopped_n = 1'b1;
							end
						end
					end
					if (off == flen_q) begin
						if (found_n) begin
							done_n = 1'b1;
						end else begin
							fstart_n = {1'b0, pos_q} + 9'd1;
							stage_n  = STG_SCAN;
						end
					end
				end
			end
		end
	end

	// Run summary, taken from the state as it stands after the final byte.
	assign field_end    = {1'b0, fstart_n} + 10'd1 + {2'b00, flen_n};
	assign drone        = found_n && (field_end <= {2'b00, pos_n});
	assign run_push     = accept && byte_last;
	assign run_drone    = drone;
	assign run_strength = drone ? signal_strength : '0;
	assign run_addr     = drone ? station_addr : '0;
	assign run_cnt      = (drone && stage_n == STG_BASIC) ? cnt_n : '0;

	always_comb begin
		for (int i = 0; i < ID_BYTES; i++) begin
			run_chars[i] = (st_we && st_idx == IDX_W'(i)) ? adv_byte : store_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			fstart_q  <= '0;
			flen_q    <= '0;
			stage_q   <= STG_SCAN;
			done_q    <= 1'b0;
			found_q   <= 1'b0;
			cnt_q     <= '0;
			stopped_q <= 1'b0;
		end else if (run_push) begin
			pos_q     <= '0;
			fstart_q  <= '0;
			flen_q    <= '0;
			stage_q   <= STG_SCAN;
			done_q    <= 1'b0;
			found_q   <= 1'b0;
			cnt_q     <= '0;
			stopped_q <= 1'b0;
		end else begin
			pos_q     <= pos_n;
			fstart_q  <= fstart_n;
			flen_q    <= flen_n;
			stage_q   <= stage_n;
			done_q    <= done_n;
			found_q   <= found_n;
			cnt_q     <= cnt_n;
			stopped_q <= stopped_n;
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_q[st_idx] <= adv_byte;
		end
	end

endmodule

### rtl/ridap_back.sv
// Result sequencer: expands one run descriptor into its stream of result items.
module ridap_back #(
	parameter int ID_BYTES = ridap_pkg::ID_BYTES_DEF,
	parameter int CNT_W    = $clog2(ID_BYTES + 1)
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        head_valid,
	output logic                                        head_pop,
	input  logic                                        run_drone,
	input  logic signed [ridap_pkg::BYTE_W-1:0]         run_strength,
	input  logic [ridap_pkg::ADDR_W-1:0]                run_addr,
	input  logic [CNT_W-1:0]                            run_cnt,
	input  logic [ID_BYTES-1:0][ridap_pkg::BYTE_W-1:0]  run_chars,
	output logic                                        out_valid,
	input  logic                                        out_ready,
	output logic                                        is_drone,
	output logic signed [ridap_pkg::BYTE_W-1:0]         hit_strength,
	output logic [ridap_pkg::ADDR_W-1:0]                hit_addr,
	output logic [ridap_pkg::OUT_N_W-1:0]               id_length,
	output logic [ridap_pkg::OUT_N_W-1:0]               char_index,
	output logic [ridap_pkg::BYTE_W-1:0]                id_char,
	output logic                                        last_result
);
	import ridap_pkg::*;

	localparam int IDX_W = (ID_BYTES > 1) ? $clog2(ID_BYTES) : 1;

	logic [IDX_W-1:0] k_q;
	logic             valid_q;
	logic             load;
	logic [CNT_W-1:0] n_items;
	logic             is_last;

	assign load     = head_valid && (!valid_q || out_ready);
	assign n_items  = (run_cnt != '0) ? run_cnt : CNT_W'(1);
	assign is_last  = (CNT_W'(k_q) + CNT_W'(1)) == n_items;
	assign head_pop = load && is_last;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			k_q     <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				k_q     <= is_last ? '0 : k_q + 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			is_drone     <= run_drone;
			hit_strength <= run_strength;
			hit_addr     <= run_addr;
			id_length    <= OUT_N_W'(run_cnt);
			char_index   <= OUT_N_W'(k_q);
			id_char      <= (run_cnt != '0) ? run_chars[k_q] : '0;
			last_result  <= is_last;
		end
	end

endmodule
